>>> rtl/bmon_pkg.sv
// Battery level monitor: shared types, register indexes, result codes and
// the charge curve tables. No dependencies; imported by every rtl/bmon file.

package bmon_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LOW_THR         = 2'd0;
  localparam logic [1:0] REG_CRIT_THR        = 2'd1;
  localparam logic [1:0] REG_POLL_INTERVAL   = 2'd2;
  localparam logic [1:0] REG_WATCHDOG_PERIOD = 2'd3;

  localparam logic [13:0] LOW_THR_RST       = 14'd1500;
  localparam logic [13:0] CRIT_THR_RST      = 14'd500;
  localparam logic [31:0] POLL_INTERVAL_RST = 32'd1000;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BUSY      = 2'd1;
  localparam logic [1:0] STATUS_NO_READS  = 2'd2;

  // Level classes
  localparam logic [1:0] LEVEL_UNKNOWN  = 2'd0;
  localparam logic [1:0] LEVEL_NORMAL   = 2'd1;
  localparam logic [1:0] LEVEL_LOW      = 2'd2;
  localparam logic [1:0] LEVEL_CRITICAL = 2'd3;

  localparam logic [15:0] MISMATCH_MV    = 16'd250;
  localparam logic [15:0] MIN_CHARGER_MV = 16'd2500;
  localparam logic [15:0] DONE_MIN_MV    = 16'd4100;
  localparam logic [15:0] FULL_CHARGE    = 16'd10000;
  localparam logic [15:0] CURVE_FLOOR_MV = 16'd3300;
  localparam logic [15:0] CURVE_TOP_MV   = 16'd4200;
  localparam logic [8:0]  KICK_MS_PER_S  = 9'd500;
  localparam logic [1:0]  DONE_BITS      = 2'd3;

  localparam int unsigned NUM_SEG = 8;

  // Curve segments: lower and upper knee voltages, charge at the lower knee,
  // and twice the slope in charge units per mV (all spans divide exactly).
  localparam logic [15:0] SEG_LO_MV [NUM_SEG] = '{
    16'd3300, 16'd3500, 16'd3600, 16'd3700, 16'd3800, 16'd3900, 16'd4000, 16'd4100
  };
  localparam logic [15:0] SEG_HI_MV [NUM_SEG] = '{
    16'd3500, 16'd3600, 16'd3700, 16'd3800, 16'd3900, 16'd4000, 16'd4100, 16'd4200
  };
  localparam logic [15:0] SEG_BASE [NUM_SEG] = '{
    16'd0, 16'd500, 16'd1000, 16'd2000, 16'd4000, 16'd6000, 16'd7800, 16'd9000
  };
  localparam logic [5:0] SEG_SLOPE2 [NUM_SEG] = '{
    6'd5, 6'd10, 6'd20, 6'd40, 6'd40, 6'd36, 6'd24, 6'd20
  };

  typedef struct packed {
    logic [13:0] low_thr;
    logic [13:0] crit_thr;
    logic [31:0] poll_interval;
    logic [24:0] kick_span;       // watchdog_period * 500 ms, zero = off
  } cfg_t;

  typedef struct packed {
    logic        kick_ok;
    logic [15:0] gauge_charge;
    logic [15:0] gauge_mv;
    logic        gauge_read_ok;
    logic [7:0]  charger_status_byte;
    logic [15:0] charger_mv;
    logic        charger_read_ok;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic        kick_issued;
    logic        gauge_agrees;
    logic        fallback_used;
    logic [1:0]  level_class;
    logic [15:0] charge_level;
    logic [15:0] eff_mv;
    logic [1:0]  status;
  } res_t;

endpackage

>>> rtl/battery_level_monitor.sv
// Battery level monitor top level: input beat register, evaluation core and
// result register. Depends on bmon_pkg, bmon_cfg, bmon_core.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[95:0]  one poll event
//  m_*      out  m_tvalid/m_tready   m_tdata[39:0]  one result per poll
//  cfg_*    in   cfg_we              cfg_index[1:0], cfg_wdata[31:0]
//
// Each beat is held in the input register, then evaluated and written to the
// result register once that register is empty or being drained: one beat
// per cycle sustained while m_tready stays high.
// The 32-bit time subtract and compare plus the curve segment lookup and
// small slope multiply set the critical path.
// rst (synchronous) loads register defaults and clears the held state.
// A stalled result register holds both stages; s_tready drops only when
// the input register is full and cannot move on.

module battery_level_monitor import bmon_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // poll beat, low bit up: time_ms[31:0], charger_read_ok[32],
  // charger_mv[48:33], charger_status_byte[56:49], gauge_read_ok[57],
  // gauge_mv[73:58], gauge_charge[89:74], kick_ok[90], zero fill[95:91]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,
  // result beat, low bit up: status[1:0], eff_mv[17:2],
  // charge_level[33:18], level_class[35:34], fallback_used[36],
  // gauge_agrees[37], kick_issued[38], zero fill[39]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res;
  res_t  out_res;
  logic  out_valid;
  logic  advance;

  bmon_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // beat moves from input register to result register
  assign advance  = item_valid && (!out_valid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_t'(s_tdata[90:0]);
    end
  end

  bmon_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};

  // an empty input stage never back-pressures the source
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_tready)
    else $error("input stage empty but not ready");

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // back-pressure only with a full input stage
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> item_valid)
    else $error("not ready with an empty input stage");

endmodule

>>> rtl/bmon_cfg.sv
// Battery level monitor: configuration registers and watchdog span product.
// Depends on bmon_pkg.

module bmon_cfg import bmon_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.low_thr       <= LOW_THR_RST;
      cfg_r.crit_thr      <= CRIT_THR_RST;
      cfg_r.poll_interval <= POLL_INTERVAL_RST;
      cfg_r.kick_span     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_THR:         cfg_r.low_thr       <= cfg_wdata[13:0];
        REG_CRIT_THR:        cfg_r.crit_thr      <= cfg_wdata[13:0];
        REG_POLL_INTERVAL:   cfg_r.poll_interval <= cfg_wdata;
        REG_WATCHDOG_PERIOD: cfg_r.kick_span <= 25'(cfg_wdata[15:0]) * 25'(KICK_MS_PER_S);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bmon_curve.sv
// Battery level monitor: piecewise-linear charge estimate from charger mV.
// Depends on bmon_pkg.

module bmon_curve import bmon_pkg::*; (
  input  logic [15:0] mv,
  input  logic        done,
  output logic [15:0] charge
);

  logic [2:0]  seg;
  logic [15:0] off_full;
  logic [7:0]  off;
  logic [13:0] prod;

  // lowest segment whose upper knee is at or above mv
  always_comb begin
    seg = 3'(NUM_SEG - 1);
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (mv <= SEG_HI_MV[i]) seg = 3'(i);
    end
  end

  assign off_full = mv - SEG_LO_MV[seg];
  assign off      = off_full[7:0];   // at most 200 inside a segment
  assign prod     = 14'(SEG_SLOPE2[seg] * off);

  always_comb begin
    if (done && mv >= DONE_MIN_MV) begin
      charge = FULL_CHARGE;
    end else if (mv <= CURVE_FLOOR_MV) begin
      charge = '0;
    end else if (mv > CURVE_TOP_MV) begin
      charge = FULL_CHARGE;
    end else begin
      charge = SEG_BASE[seg] + {3'b000, prod[13:1]};
    end
  end

endmodule

>>> rtl/bmon_core.sv
// Battery level monitor: poll decision, agreement check, level classing,
// watchdog timing and the held state. Depends on bmon_pkg, bmon_curve.

module bmon_core import bmon_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [31:0] last_poll_time;
  logic [31:0] last_kick_time;
  logic        chg_valid;
  logic        gau_valid;
  logic        agree_flag;
  logic        fallback_flag;
  logic [15:0] held_mv;
  logic [15:0] held_charge;
  logic [1:0]  held_level;

  logic [31:0] poll_age;
  logic [31:0] kick_age;
  logic        busy;
  logic        ch_usable;
  logic [15:0] diff_mv;
  logic        agree_next;
  logic        fallback_next;
  logic [15:0] mv_next;
  logic [15:0] charge_next;
  logic [15:0] curve_charge;
  logic [1:0]  level_next;
  logic        kick;
  logic        done;

  assign poll_age = item.time_ms - last_poll_time;
  assign kick_age = item.time_ms - last_kick_time;
  assign busy     = (chg_valid || gau_valid) && (poll_age < cfg.poll_interval);

  assign ch_usable = item.charger_read_ok && (item.charger_mv >= MIN_CHARGER_MV);
  assign diff_mv   = (item.gauge_mv > item.charger_mv)
                   ? item.gauge_mv - item.charger_mv
                   : item.charger_mv - item.gauge_mv;

  assign agree_next    = item.gauge_read_ok && (!ch_usable || diff_mv <= MISMATCH_MV);
  assign fallback_next = !agree_next && ch_usable;
  assign done          = (item.charger_status_byte[4:3] == DONE_BITS);

  bmon_curve u_curve (
    .mv     (item.charger_mv),
    .done   (done),
    .charge (curve_charge)
  );

  always_comb begin
    if (agree_next) begin
      mv_next     = item.gauge_mv;
      charge_next = item.gauge_charge;
    end else if (fallback_next) begin
      mv_next     = item.charger_mv;
      charge_next = curve_charge;
    end else begin
      mv_next     = '0;
      charge_next = '0;
    end
  end

  always_comb begin
    if (!(agree_next || fallback_next)) begin
      level_next = LEVEL_UNKNOWN;
    end else if (charge_next <= {2'b00, cfg.crit_thr}) begin
      level_next = LEVEL_CRITICAL;
    end else if (charge_next <= {2'b00, cfg.low_thr}) begin
      level_next = LEVEL_LOW;
    end else begin
      level_next = LEVEL_NORMAL;
    end
  end

  assign kick = (cfg.kick_span != '0) && (kick_age >= {7'd0, cfg.kick_span});

  always_comb begin
    if (busy) begin
      res.status        = STATUS_BUSY;
      res.eff_mv        = held_mv;
      res.charge_level  = held_charge;
      res.level_class   = held_level;
      res.fallback_used = fallback_flag;
      res.gauge_agrees  = agree_flag;
      res.kick_issued   = 1'b0;
    end else begin
      res.status        = (!item.charger_read_ok && !item.gauge_read_ok)
                        ? STATUS_NO_READS : STATUS_OK;
      res.eff_mv        = mv_next;
      res.charge_level  = charge_next;
      res.level_class   = level_next;
      res.fallback_used = fallback_next;
      res.gauge_agrees  = agree_next;
      res.kick_issued   = kick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time <= '0;
      last_kick_time <= '0;
      chg_valid      <= 1'b0;
      gau_valid      <= 1'b0;
      agree_flag     <= 1'b0;
      fallback_flag  <= 1'b0;
      held_mv        <= '0;
      held_charge    <= '0;
      held_level     <= LEVEL_UNKNOWN;
    end else if (fire && !busy) begin
      last_poll_time <= item.time_ms;
      chg_valid      <= item.charger_read_ok;
      gau_valid      <= item.gauge_read_ok;
      agree_flag     <= agree_next;
      fallback_flag  <= fallback_next;
      held_mv        <= mv_next;
      held_charge    <= charge_next;
      held_level     <= level_next;
      if (kick && item.kick_ok) last_kick_time <= item.time_ms;
    end
  end

  // a level is only known when some source was trusted
  a_level_source: assert property (@(posedge clk) disable iff (rst)
    (held_level != LEVEL_UNKNOWN) |-> (agree_flag || fallback_flag))
    else $error("held level known without a trusted source");

  // gauge and curve paths are exclusive
  a_path_excl: assert property (@(posedge clk) disable iff (rst)
    !(agree_flag && fallback_flag))
    else $error("agree and fallback both set");

  // a skipped poll leaves the timing state alone
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && busy) |=> ($stable(last_poll_time) && $stable(last_kick_time)))
    else $error("busy poll changed timing state");

endmodule
